>>> hdl/ppzb_pkg.sv
// shared constants, codes and helpers for the point projection z-buffer
package ppzb_pkg;

   localparam int SYM_W   = 8;
   localparam int DEPTH_W = 24;
   localparam int ENTRY_W = SYM_W + DEPTH_W;

   localparam logic [SYM_W-1:0]   BLANK_SYMBOL = 8'd32;
   localparam logic [DEPTH_W-1:0] OOZ_MAX      = 24'hFF_FFFF;

   // configuration register indexes
   localparam logic [3:0] CSR_SIN_AX   = 4'd0;
   localparam logic [3:0] CSR_COS_AX   = 4'd1;
   localparam logic [3:0] CSR_SIN_AY   = 4'd2;
   localparam logic [3:0] CSR_COS_AY   = 4'd3;
   localparam logic [3:0] CSR_SIN_AZ   = 4'd4;
   localparam logic [3:0] CSR_COS_AZ   = 4'd5;
   localparam logic [3:0] CSR_CAM_DIST = 4'd6;
   localparam logic [3:0] CSR_FOCAL    = 4'd7;

   // multiply steps of the sequencer
   localparam logic [3:0] STEP_SXY  = 4'd0;
   localparam logic [3:0] STEP_CXZ  = 4'd1;
   localparam logic [3:0] STEP_CXY  = 4'd2;
   localparam logic [3:0] STEP_SXZ  = 4'd3;
   localparam logic [3:0] STEP_CYX  = 4'd4;
   localparam logic [3:0] STEP_SYA  = 4'd5;
   localparam logic [3:0] STEP_CZP  = 4'd6;
   localparam logic [3:0] STEP_SZB  = 4'd7;
   localparam logic [3:0] STEP_CZB  = 4'd8;
   localparam logic [3:0] STEP_SZP  = 4'd9;
   localparam logic [3:0] STEP_CYA  = 4'd10;
   localparam logic [3:0] STEP_SYX  = 4'd11;
   localparam logic [3:0] STEP_FOOZ = 4'd12;
   localparam logic [3:0] STEP_COLP = 4'd13;
   localparam logic [3:0] STEP_ROWP = 4'd14;
   localparam logic [3:0] STEP_ROWW = 4'd15;

   // arithmetic shift right that rounds toward zero
   function automatic logic signed [63:0] trunc_sra(input logic signed [63:0] v,
                                                    input int unsigned sh);
      logic signed [63:0] bias;
      begin
         bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
         return (v + bias) >>> sh;
      end
   endfunction

endpackage

>>> hdl/point_project_zbuffer_plot.sv
// A plot runs through the bit-serial shared multiplier (at most 16 multiplies) and the
// 24-step restoring divider; the divider is skipped when the reciprocal saturates, and
// only the rotation multiplies run when the depth is not positive.
// A read and clear answers through the registered cell memory read.
// Throughput: one item at a time; the next item is taken once the previous result sits in
// the output register. Reset is synchronous; afterwards a clearing pass blanks every
// cell of the memory before items are taken.
module point_project_zbuffer_plot
   import ppzb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 160,
   parameter int SCREEN_HEIGHT = 44
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // point_x, point_y, point_z, symbol, cell_index, zero pad
   input  logic        req_tuser,  // operation
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // read_symbol, hit_index, zero pad
   output logic        rsp_tuser,  // plotted
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam logic [63:0] CELL_LIMIT = 64'(CELL_COUNT);
   localparam logic signed [63:0] COL_BIAS = 64'(SCREEN_WIDTH / 2) <<< 40;
   localparam logic signed [63:0] ROW_BIAS = 64'(SCREEN_HEIGHT / 2) <<< 40;
   localparam logic [63:0] WIDTH_B = 64'(SCREEN_WIDTH);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_LOAD   = 4'd2;
   localparam logic [3:0] ST_MUL    = 4'd3;
   localparam logic [3:0] ST_PROJ   = 4'd4;
   localparam logic [3:0] ST_ZCHK   = 4'd5;
   localparam logic [3:0] ST_DIV    = 4'd6;
   localparam logic [3:0] ST_COLROW = 4'd7;
   localparam logic [3:0] ST_IDX    = 4'd8;
   localparam logic [3:0] ST_RDISS  = 4'd9;
   localparam logic [3:0] ST_MEMCHK = 4'd10;
   localparam logic [3:0] ST_OUT    = 4'd11;

   localparam logic [4:0] LEN16 = 5'd15;
   localparam logic [4:0] LEN32 = 5'd31;

   // control and configuration registers
   logic [3:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] sx_ff, sx_in, cx_ff, cx_in, sy_ff, sy_in;
   logic signed [15:0] cy_ff, cy_in, sz_ff, sz_in, cz_ff, cz_in;
   logic [9:0]  cd_ff, cd_in;
   logic [7:0]  fs_ff, fs_in;

   // payload registers
   logic        op_rd_ff, op_rd_in;
   logic signed [15:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [7:0]  sym_ff, sym_in;
   logic [12:0] cidx_ff, cidx_in;
   logic signed [63:0] t_ff, t_in, a_ff, a_in, b_ff, b_in, p_ff, p_in;
   logic signed [63:0] rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic signed [31:0] x16_ff, x16_in, y16_ff, y16_in;
   logic signed [39:0] z16_ff, z16_in;
   logic [23:0] ooz_ff, ooz_in;
   logic [31:0] fo_ff, fo_in;
   logic signed [31:0] col_ff, col_in, row_ff, row_in;
   logic [41:0] rem_ff, rem_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic signed [31:0] ma_ff, ma_in;
   logic signed [63:0] mb_ff, mb_in, macc_ff, macc_in;
   logic [4:0]  mcnt_ff, mcnt_in, mlen_ff, mlen_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic        res_plot_ff, res_plot_in, out_plot_ff, out_plot_in;
   logic [7:0]  res_sym_ff, res_sym_in, out_sym_ff, out_sym_in;
   logic [12:0] res_hit_ff, res_hit_in, out_hit_ff, out_hit_in;

   // cell memory: symbol over depth
   logic [ENTRY_W-1:0] mem [CELL_COUNT];
   logic [ENTRY_W-1:0] rd_q_ff;
   logic               rd_en, wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ADDR_W-1:0]  wr_addr;

   // helpers
   logic signed [63:0] addend, prod, z64, idx_w;
   logic               mlast, ge;
   logic [41:0]        r2, dz;
   logic [31:0]        cidx_wide, addr_wide;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_plot_ff;
   assign rsp_tdata  = {3'd0, out_hit_ff, out_sym_ff};

   always_comb begin
      // defaults hold
      state_in = state_ff;  step_in = step_ff;  clr_in = clr_ff;
      sx_in = sx_ff;  cx_in = cx_ff;  sy_in = sy_ff;  cy_in = cy_ff;
      sz_in = sz_ff;  cz_in = cz_ff;  cd_in = cd_ff;  fs_in = fs_ff;
      op_rd_in = op_rd_ff;  x_in = x_ff;  y_in = y_ff;  z_in = z_ff;
      sym_in = sym_ff;  cidx_in = cidx_ff;
      t_in = t_ff;  a_in = a_ff;  b_in = b_ff;  p_in = p_ff;
      rx_in = rx_ff;  ry_in = ry_ff;  rz_in = rz_ff;
      x16_in = x16_ff;  y16_in = y16_ff;  z16_in = z16_ff;
      ooz_in = ooz_ff;  fo_in = fo_ff;  col_in = col_ff;  row_in = row_ff;
      rem_in = rem_ff;  dcnt_in = dcnt_ff;
      ma_in = ma_ff;  mb_in = mb_ff;  macc_in = macc_ff;
      mcnt_in = mcnt_ff;  mlen_in = mlen_ff;
      addr_in = addr_ff;
      res_plot_in = res_plot_ff;  res_sym_in = res_sym_ff;  res_hit_in = res_hit_ff;
      out_plot_in = out_plot_ff;  out_sym_in = out_sym_ff;  out_hit_in = out_hit_ff;
      rd_en = 1'b0;  wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = {BLANK_SYMBOL, {DEPTH_W{1'b0}}};

      // bit-serial multiply step
      addend = ma_ff[0] ? mb_ff : 64'sd0;
      mlast  = (mcnt_ff == mlen_ff);
      prod   = mlast ? (macc_ff - addend) : (macc_ff + addend);

      // restoring divide step
      r2 = {rem_ff[40:0], 1'b0};
      dz = {2'b00, z16_ff};
      ge = (r2 >= dz);

      z64   = trunc_sra(rz_ff, 34) + $signed({38'd0, cd_ff, 16'd0});
      idx_w = {{32{col_ff[31]}}, col_ff} + rz_ff;
      cidx_wide = 32'(cidx_ff);
      addr_wide = 32'(addr_ff);

      // response register drains
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SIN_AX:   sx_in = csr_data;
            CSR_COS_AX:   cx_in = csr_data;
            CSR_SIN_AY:   sy_in = csr_data;
            CSR_COS_AY:   cy_in = csr_data;
            CSR_SIN_AZ:   sz_in = csr_data;
            CSR_COS_AZ:   cz_in = csr_data;
            CSR_CAM_DIST: cd_in = csr_data[9:0];
            CSR_FOCAL:    fs_in = csr_data[7:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // blank every cell after reset
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (32'(clr_ff) == CELL_COUNT - 1) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         // take one request beat
         ST_IDLE: begin
            if (req_tvalid) begin
               op_rd_in = req_tuser;
               x_in     = req_tdata[15:0];
               y_in     = req_tdata[31:16];
               z_in     = req_tdata[47:32];
               sym_in   = req_tdata[55:48];
               cidx_in  = req_tdata[68:56];
               res_plot_in = 1'b0;  res_sym_in = 8'd0;  res_hit_in = 13'd0;
               if (req_tuser) begin
                  state_in = ST_RDISS;
               end else begin
                  step_in  = STEP_SXY;
                  state_in = ST_LOAD;
               end
            end
         end
         // set up multiplier operands for the current step
         ST_LOAD: begin
            macc_in = 64'sd0;
            mcnt_in = 5'd0;
            mlen_in = LEN16;
            unique case (step_ff)
               STEP_SXY:  begin ma_in = 32'(sx_ff); mb_in = 64'(y_ff); end
               STEP_CXZ:  begin ma_in = 32'(cx_ff); mb_in = 64'(z_ff); end
               STEP_CXY:  begin ma_in = 32'(cx_ff); mb_in = 64'(y_ff); end
               STEP_SXZ:  begin ma_in = 32'(sx_ff); mb_in = 64'(z_ff); end
               STEP_CYX:  begin ma_in = 32'(cy_ff); mb_in = 64'(x_ff); end
               STEP_SYA:  begin ma_in = 32'(sy_ff); mb_in = a_ff; end
               STEP_CZP:  begin ma_in = 32'(cz_ff); mb_in = p_ff; end
               STEP_SZB:  begin ma_in = 32'(sz_ff); mb_in = b_ff; end
               STEP_CZB:  begin ma_in = 32'(cz_ff); mb_in = b_ff; end
               STEP_SZP:  begin ma_in = 32'(sz_ff); mb_in = p_ff; end
               STEP_CYA:  begin ma_in = 32'(cy_ff); mb_in = a_ff; end
               STEP_SYX:  begin ma_in = 32'(sy_ff); mb_in = 64'(x_ff); end
               STEP_FOOZ: begin ma_in = {24'd0, fs_ff}; mb_in = {40'd0, ooz_ff}; end
               STEP_COLP: begin
                  ma_in = x16_ff;  mb_in = {31'd0, fo_ff, 1'b0};  mlen_in = LEN32;
               end
               STEP_ROWP: begin
                  ma_in = y16_ff;  mb_in = {32'd0, fo_ff};  mlen_in = LEN32;
               end
               STEP_ROWW: begin
                  ma_in = row_ff;  mb_in = WIDTH_B;  mlen_in = LEN32;
               end
               default: ;
            endcase
            state_in = ST_MUL;
         end
         // shift-add multiply, sign bit subtracts
         ST_MUL: begin
            macc_in = prod;
            ma_in   = ma_ff >>> 1;
            mb_in   = mb_ff <<< 1;
            mcnt_in = mcnt_ff + 1'b1;
            if (mlast) begin
               step_in  = step_ff + 1'b1;
               state_in = ST_LOAD;
               unique case (step_ff)
                  STEP_SXY:  t_in = prod;
                  STEP_CXZ:  a_in = t_ff - prod;
                  STEP_CXY:  t_in = prod;
                  STEP_SXZ:  b_in = t_ff + prod;
                  STEP_CYX:  t_in = prod <<< 14;
                  STEP_SYA:  p_in = prod + t_ff;
                  STEP_CZP:  rx_in = prod;
                  STEP_SZB:  rx_in = rx_ff + (prod <<< 14);
                  STEP_CZB:  ry_in = prod <<< 14;
                  STEP_SZP:  ry_in = ry_ff - prod;
                  STEP_CYA:  rz_in = -prod;
                  STEP_SYX: begin
                     rz_in    = (rz_ff + (prod <<< 14)) <<< 14;
                     state_in = ST_PROJ;
                  end
                  STEP_FOOZ: fo_in = prod[31:0];
                  STEP_COLP: rx_in = prod;  // column product
                  STEP_ROWP: begin
                     ry_in    = prod;         // row product
                     state_in = ST_COLROW;
                  end
                  STEP_ROWW: begin
                     rz_in    = prod;         // row times width
                     state_in = ST_IDX;
                  end
                  default: ;
               endcase
            end
         end
         // rotated coordinates back to 16 fraction bits
         ST_PROJ: begin
            x16_in   = 32'(trunc_sra(rx_ff, 34));
            y16_in   = 32'(trunc_sra(ry_ff, 34));
            z16_in   = z64[39:0];
            state_in = ST_ZCHK;
         end
         // depth checks before the reciprocal
         ST_ZCHK: begin
            priority if (z16_ff[39] || z16_ff == 40'sd0) begin
               state_in = ST_OUT;
            end else if (z16_ff <= 40'sd65536) begin
               ooz_in   = OOZ_MAX;
               step_in  = STEP_FOOZ;
               state_in = ST_LOAD;
            end else begin
               rem_in   = 42'd65536;
               ooz_in   = 24'd0;
               dcnt_in  = 5'd23;
               state_in = ST_DIV;
            end
         end
         // one quotient bit a cycle
         ST_DIV: begin
            rem_in = ge ? (r2 - dz) : r2;
            ooz_in = {ooz_ff[22:0], ge};
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == 5'd0) begin
               step_in  = STEP_FOOZ;
               state_in = ST_LOAD;
            end
         end
         // screen column and row, truncated toward zero
         ST_COLROW: begin
            col_in   = 32'(trunc_sra(rx_ff + COL_BIAS, 40));
            row_in   = 32'(trunc_sra(ry_ff + ROW_BIAS, 40));
            step_in  = STEP_ROWW;
            state_in = ST_LOAD;
         end
         // range check the cell and fetch its entry
         ST_IDX: begin
            if (!idx_w[63] && $unsigned(idx_w) < CELL_LIMIT) begin
               addr_in  = idx_w[ADDR_W-1:0];
               rd_en    = 1'b1;
               state_in = ST_MEMCHK;
            end else begin
               state_in = ST_OUT;
            end
         end
         // read request: fetch the cell if it exists
         ST_RDISS: begin
            if (cidx_wide < 32'(CELL_COUNT)) begin
               addr_in  = cidx_wide[ADDR_W-1:0];
               rd_en    = 1'b1;
               state_in = ST_MEMCHK;
            end else begin
               state_in = ST_OUT;
            end
         end
         // depth compare and write back
         ST_MEMCHK: begin
            if (op_rd_ff) begin
               res_sym_in = rd_q_ff[ENTRY_W-1:DEPTH_W];
               wr_en      = 1'b1;
            end else if (ooz_ff > rd_q_ff[DEPTH_W-1:0]) begin
               wr_en       = 1'b1;
               wr_data     = {sym_ff, ooz_ff};
               res_plot_in = 1'b1;
               res_hit_in  = addr_wide[12:0];
            end
            state_in = ST_OUT;
         end
         // hand the result to the output register
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_plot_in  = res_plot_ff;
               out_sym_in   = res_sym_ff;
               out_hit_in   = res_hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= STEP_SXY;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sx_ff <= 16'sd0;  cx_ff <= 16'sd16384;
         sy_ff <= 16'sd0;  cy_ff <= 16'sd16384;
         sz_ff <= 16'sd0;  cz_ff <= 16'sd16384;
         cd_ff <= 10'd100;
         fs_ff <= 8'd40;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         sx_ff <= sx_in;  cx_ff <= cx_in;
         sy_ff <= sy_in;  cy_ff <= cy_in;
         sz_ff <= sz_in;  cz_ff <= cz_in;
         cd_ff <= cd_in;
         fs_ff <= fs_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_rd_ff <= op_rd_in;  x_ff <= x_in;  y_ff <= y_in;  z_ff <= z_in;
      sym_ff <= sym_in;  cidx_ff <= cidx_in;
      t_ff <= t_in;  a_ff <= a_in;  b_ff <= b_in;  p_ff <= p_in;
      rx_ff <= rx_in;  ry_ff <= ry_in;  rz_ff <= rz_in;
      x16_ff <= x16_in;  y16_ff <= y16_in;  z16_ff <= z16_in;
      ooz_ff <= ooz_in;  fo_ff <= fo_in;  col_ff <= col_in;  row_ff <= row_in;
      rem_ff <= rem_in;  dcnt_ff <= dcnt_in;
      ma_ff <= ma_in;  mb_ff <= mb_in;  macc_ff <= macc_in;
      mcnt_ff <= mcnt_in;  mlen_ff <= mlen_in;
      addr_ff <= addr_in;
      res_plot_ff <= res_plot_in;  res_sym_ff <= res_sym_in;  res_hit_ff <= res_hit_in;
      out_plot_ff <= out_plot_in;  out_sym_ff <= out_sym_in;  out_hit_ff <= out_hit_in;
   end

   // cell memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[addr_in];
      end
   end

   // checks
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_tvalid)
      else $error("response during clearing pass");

   a_plot_has_no_symbol: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("plot result carries a read symbol");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < 32'(CELL_COUNT)))
      else $error("cell write out of range");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (mcnt_ff <= mlen_ff))
      else $error("multiplier overran its length");

endmodule
